// ===== src/mceo_pkg.sv =====
// Shared types, constants and helper functions of the mecanum encoder odometry block.
package mceo_pkg;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned ITER_W       = $clog2(CORDIC_STEPS);

    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [16:0] PI_Q13      = 17'sd25736;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [34:0] ROUND_Q15   = 35'sd16384;
    localparam logic        [41:0] ROUND_Q17   = 42'd65536;
    localparam logic        [23:0] MPC_RESET   = 24'd65536;

    localparam logic [3:0] STEP_LAST = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MAC
    } t_state;

    typedef struct packed {
        logic               done;
        logic signed [15:0] sin;
        logic signed [15:0] cos;
    } t_trig;

    function automatic logic signed [32:0] atan_of(input logic [ITER_W-1:0] idx);
        logic signed [32:0] v;
        case (idx)
            4'd0:    v = 33'sd421657428;
            4'd1:    v = 33'sd248918914;
            4'd2:    v = 33'sd131521918;
            4'd3:    v = 33'sd66762579;
            4'd4:    v = 33'sd33510843;
            4'd5:    v = 33'sd16771757;
            4'd6:    v = 33'sd8387925;
            4'd7:    v = 33'sd4194219;
            4'd8:    v = 33'sd2097141;
            4'd9:    v = 33'sd1048575;
            4'd10:   v = 33'sd524288;
            4'd11:   v = 33'sd262144;
            4'd12:   v = 33'sd131072;
            4'd13:   v = 33'sd65536;
            4'd14:   v = 33'sd32768;
            default: v = 33'sd16384;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [59:0] v);
        logic signed [47:0] r;
        if (v[59:47] == {13{1'b0}} || v[59:47] == {13{1'b1}}) begin
            r = v[47:0];
        end else if (v[59]) begin
            r = {1'b1, {47{1'b0}}};
        end else begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== src/mceo_cordic.sv =====
// Iterative CORDIC that turns a Q3.13 heading into Q1.15 sine and cosine.
module mceo_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [15:0]  i_yaw,
    output mceo_pkg::t_trig     o_trig
);

    logic                            r_busy;
    logic                            r_fin;
    logic                            r_done;
    logic [mceo_pkg::ITER_W-1:0]     r_iter;
    logic signed [33:0]              r_x;
    logic signed [33:0]              r_y;
    logic signed [32:0]              r_z;
    logic                            r_neg;
    logic signed [15:0]              r_sin;
    logic signed [15:0]              r_cos;

    logic signed [16:0] yaw_ext;
    logic signed [16:0] yaw_red;
    logic               yaw_neg;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [32:0] atan_v;
    logic signed [34:0] x_rnd;
    logic signed [34:0] y_rnd;
    logic signed [19:0] x_q15;
    logic signed [19:0] y_q15;
    logic signed [19:0] x_fix;
    logic signed [19:0] y_fix;

    always_comb begin
        yaw_ext = {i_yaw[15], i_yaw};
        yaw_red = yaw_ext;
        yaw_neg = 1'b0;
        if (yaw_ext > mceo_pkg::HALF_PI_Q13) begin
            yaw_red = yaw_ext - mceo_pkg::PI_Q13;
            yaw_neg = 1'b1;
        end else if (yaw_ext < -mceo_pkg::HALF_PI_Q13) begin
            yaw_red = yaw_ext + mceo_pkg::PI_Q13;
            yaw_neg = 1'b1;
        end
    end

    assign x_sh   = r_x >>> r_iter;
    assign y_sh   = r_y >>> r_iter;
    assign atan_v = mceo_pkg::atan_of(r_iter);

    assign x_rnd = {r_x[33], r_x} + mceo_pkg::ROUND_Q15;
    assign y_rnd = {r_y[33], r_y} + mceo_pkg::ROUND_Q15;
    assign x_q15 = x_rnd[34:15];
    assign y_q15 = y_rnd[34:15];
    assign x_fix = r_neg ? -x_q15 : x_q15;
    assign y_fix = r_neg ? -y_q15 : y_q15;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == mceo_pkg::ITER_W'(mceo_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= mceo_pkg::CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= {yaw_red, 16'b0};
            r_neg <= yaw_neg;
        end else if (r_busy) begin
            if (!r_z[32]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_v;
            end
        end
        if (r_fin) begin
            r_cos <= mceo_pkg::sat16(x_fix);
            r_sin <= mceo_pkg::sat16(y_fix);
        end
    end

    assign o_trig.done = r_done;
    assign o_trig.sin  = r_sin;
    assign o_trig.cos  = r_cos;

endmodule

// ===== src/mecanum_encoder_odometry.sv =====
// Top level of the mecanum wheel dead-reckoning odometry block.
//
// Channel  Direction  Handshake                  Payload
// in       sink       i_in_valid / o_in_stall    i_wheel_total_0..3, i_yaw_angle
// out      source     o_out_valid / i_out_stall  o_position_x, o_position_y
// cfg      sink       i_cfg_we                   i_cfg_data (distance per count)
//
// Each sample is worked in order: the wheel deltas are captured, sixteen
// CORDIC iterations run, rounding and hand-off follow, then ten steps of the
// shared 35 by 25 bit multiplier for rotation, scaling and the position sums.
// Reset is synchronous and active low; it clears the previous totals, the
// positions and restores the distance register. A stalled result waits in the
// output register while the next sample is already taken and worked on.
module mecanum_encoder_odometry (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [31:0]  i_wheel_total_0,
    input  logic signed [31:0]  i_wheel_total_1,
    input  logic signed [31:0]  i_wheel_total_2,
    input  logic signed [31:0]  i_wheel_total_3,
    input  logic signed [15:0]  i_yaw_angle,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [47:0]  o_position_x,
    output logic signed [47:0]  o_position_y,
    input  logic                i_cfg_we,
    input  logic [23:0]         i_cfg_data
);

    mceo_pkg::t_state   r_state;
    mceo_pkg::t_state   n_state;
    logic [3:0]         r_step;
    logic [23:0]        r_mpc;
    logic [31:0]        r_prev [4];
    logic signed [31:0] r_d [4];
    logic signed [32:0] r_p [4];
    logic signed [33:0] r_sx;
    logic signed [33:0] r_sy;
    logic signed [59:0] r_prod;
    logic signed [59:0] r_acc;
    logic signed [50:0] r_rx;
    logic signed [50:0] r_ry;
    logic signed [47:0] r_wx;
    logic signed [47:0] r_wy;
    logic               r_out_valid;
    logic signed [47:0] r_out_x;
    logic signed [47:0] r_out_y;

    mceo_pkg::t_trig    trig;
    logic               accept;
    logic               commit;
    logic signed [34:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [59:0] mul_p;
    logic [41:0]        frac_sum;
    logic signed [59:0] frac;
    logic signed [59:0] wx_sum;
    logic signed [59:0] wy_sum;
    logic signed [47:0] wy_new;

    mceo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_yaw   (i_yaw_angle),
        .o_trig  (trig)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mceo_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = mceo_pkg::ST_TRIG;
                end
            end
            mceo_pkg::ST_TRIG: begin
                if (trig.done) begin
                    n_state = mceo_pkg::ST_MAC;
                end
            end
            mceo_pkg::ST_MAC: begin
                if (commit) begin
                    n_state = mceo_pkg::ST_IDLE;
                end
            end
            default: n_state = mceo_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        accept     = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            mceo_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
            end
            mceo_pkg::ST_TRIG: begin
                o_in_stall = 1'b1;
            end
            mceo_pkg::ST_MAC: begin
                commit = (r_step == mceo_pkg::STEP_LAST) && !(r_out_valid && i_out_stall);
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        case (r_step)
            4'd0:    begin mul_a = {r_sx[33], r_sx};       mul_b = 25'(trig.cos); end
            4'd1:    begin mul_a = {r_sy[33], r_sy};       mul_b = 25'(trig.sin); end
            4'd2:    begin mul_a = {r_sx[33], r_sx};       mul_b = 25'(trig.sin); end
            4'd3:    begin mul_a = {r_sy[33], r_sy};       mul_b = 25'(trig.cos); end
            4'd4:    begin mul_a = {r_rx[50], r_rx[50:17]}; mul_b = {1'b0, r_mpc}; end
            4'd5:    begin mul_a = {18'b0, r_rx[16:0]};    mul_b = {1'b0, r_mpc}; end
            4'd6:    begin mul_a = {r_ry[50], r_ry[50:17]}; mul_b = {1'b0, r_mpc}; end
            4'd7:    begin mul_a = {18'b0, r_ry[16:0]};    mul_b = {1'b0, r_mpc}; end
            default: begin mul_a = '0;                     mul_b = '0; end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign frac_sum = {1'b0, r_prod[40:0]} + mceo_pkg::ROUND_Q17;
    assign frac     = {35'b0, frac_sum[41:17]};
    assign wx_sum   = {{12{r_wx[47]}}, r_wx} + r_acc;
    assign wy_sum   = {{12{r_wy[47]}}, r_wy} + r_acc;
    assign wy_new   = mceo_pkg::sat48(wy_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mceo_pkg::ST_IDLE;
            r_step      <= '0;
            r_mpc       <= mceo_pkg::MPC_RESET;
            r_prev[0]   <= '0;
            r_prev[1]   <= '0;
            r_prev[2]   <= '0;
            r_prev[3]   <= '0;
            r_wx        <= '0;
            r_wy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mpc <= i_cfg_data;
            end
            if (accept) begin
                r_prev[0] <= i_wheel_total_0;
                r_prev[1] <= i_wheel_total_1;
                r_prev[2] <= i_wheel_total_2;
                r_prev[3] <= i_wheel_total_3;
            end
            if (trig.done) begin
                r_step <= '0;
            end else if (r_state == mceo_pkg::ST_MAC && r_step != mceo_pkg::STEP_LAST) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == mceo_pkg::ST_MAC && r_step == 4'd7) begin
                r_wx <= mceo_pkg::sat48(wx_sum);
            end
            if (commit) begin
                r_wy        <= wy_new;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_d[0] <= i_wheel_total_0 - r_prev[0];
            r_d[1] <= i_wheel_total_1 - r_prev[1];
            r_d[2] <= i_wheel_total_2 - r_prev[2];
            r_d[3] <= i_wheel_total_3 - r_prev[3];
        end
        r_p[0] <= {r_d[1][31], r_d[1]} - {r_d[0][31], r_d[0]};
        r_p[1] <= {r_d[2][31], r_d[2]} - {r_d[3][31], r_d[3]};
        r_p[2] <= {r_d[0][31], r_d[0]} + {r_d[1][31], r_d[1]};
        r_p[3] <= {r_d[2][31], r_d[2]} + {r_d[3][31], r_d[3]};
        r_sx   <= {r_p[0][32], r_p[0]} + {r_p[1][32], r_p[1]};
        r_sy   <= {r_p[3][32], r_p[3]} - {r_p[2][32], r_p[2]};
        r_prod <= mul_p;
        if (r_state == mceo_pkg::ST_MAC) begin
            case (r_step)
                4'd1:    r_acc <= r_prod;
                4'd2:    r_rx  <= r_acc[50:0] - r_prod[50:0];
                4'd3:    r_acc <= r_prod;
                4'd4:    r_ry  <= r_acc[50:0] + r_prod[50:0];
                4'd5:    r_acc <= r_prod;
                4'd6:    r_acc <= r_acc + frac;
                4'd7:    r_acc <= r_prod;
                4'd8:    r_acc <= r_acc + frac;
                default: r_acc <= r_acc;
            endcase
        end
        if (commit) begin
            r_out_x <= r_wx;
            r_out_y <= wy_new;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_position_x = r_out_x;
    assign o_position_y = r_out_y;

    a_trig_in_trig_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig.done |-> r_state == mceo_pkg::ST_TRIG)
        else $error("trig result arrived outside the trig phase");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mceo_pkg::ST_MAC |-> r_step <= mceo_pkg::STEP_LAST)
        else $error("multiply step counter ran past its last step");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mceo_pkg::ST_MAC && r_step == mceo_pkg::STEP_LAST
         && o_out_valid && i_out_stall)
        |=> (r_state == mceo_pkg::ST_MAC && o_out_valid && $stable(o_position_y)))
        else $error("pending beat overwritten by a new result");

endmodule
